### rtl/pfs_pkg.sv
`timescale 1ns / 1ps

package pfs_pkg;

  // Default build values for the top-level parameters.
  localparam int MAX_SEP_LEN_DEF     = 4;
  localparam int FIELD_NUM_WIDTH_DEF = 16;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE  = 2'd2;

  localparam logic [31:0] SEP_BYTES_RST = 32'h0000_0020;
  localparam logic [2:0]  SEP_LEN_RST   = 3'd1;
  localparam logic        COLLAPSE_RST  = 1'b1;

  // Request opcodes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_EOF       = 2'd1,
    KIND_EOL_EMPTY = 2'd2
  } kind_e;

  // One result, without the field number (shared by all results of a request).
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        done;
  } res_t;

  // Separator byte i; positions beyond the 32-bit register compare as zero.
  function automatic logic [7:0] sep_byte(input logic [31:0] sep, input int idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < 4) begin
      b = sep[8*idx +: 8];
    end
    return b;
  endfunction

endpackage

### rtl/pfs_if.sv
`timescale 1ns / 1ps

interface pfs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface pfs_out_if import pfs_pkg::*; #(
  parameter int FNW = FIELD_NUM_WIDTH_DEF
);
  logic           valid;
  logic           ready;
  logic [1:0]     kind;
  logic [7:0]     out_byte;
  logic [FNW-1:0] field_number;
  logic           line_done;

  modport source (output valid, output kind, output out_byte, output field_number,
                  output line_done, input ready);
  modport sink   (input valid, input kind, input out_byte, input field_number,
                  input line_done, output ready);
endinterface

### rtl/pfs_step.sv
`timescale 1ns / 1ps

module pfs_step import pfs_pkg::*; #(
  parameter int MAX_SEP_LEN     = MAX_SEP_LEN_DEF,
  parameter int FIELD_NUM_WIDTH = FIELD_NUM_WIDTH_DEF,
  localparam int CW             = $clog2(MAX_SEP_LEN + 1)
) (
  input  logic                       op_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [31:0]                sep_bytes_i,
  input  logic [2:0]                 sep_len_i,
  input  logic                       collapse_i,
  input  logic [7:0]                 pend_i [MAX_SEP_LEN],
  input  logic [CW-1:0]              pcnt_i,
  input  logic [FIELD_NUM_WIDTH-1:0] fields_i,
  input  logic                       vhc_i,
  input  logic                       skip_i,
  output logic [7:0]                 pend_o [MAX_SEP_LEN],
  output logic [CW-1:0]              pcnt_o,
  output logic [FIELD_NUM_WIDTH-1:0] fields_o,
  output logic                       vhc_o,
  output logic                       skip_o,
  output res_t [MAX_SEP_LEN-1:0]     res_o,
  output logic [CW-1:0]              res_cnt_o,
  output logic [FIELD_NUM_WIDTH-1:0] res_field_o
);

  logic [3:0]    len_ext;
  logic [CW-1:0] eff_len;
  logic [7:0]    win [MAX_SEP_LEN];
  logic [CW-1:0] wcnt;
  logic [MAX_SEP_LEN:0] ok;
  logic [CW-1:0] sel;
  logic [CW-1:0] rem;
  logic          hit;
  logic          skip_mid;
  logic          emit_eof;
  logic          fields_max;

  assign fields_max  = &fields_i;
  assign res_field_o = fields_max ? fields_i : fields_i + 1'b1;

  // Separator length clamped to 1..MAX_SEP_LEN.
  assign len_ext = {1'b0, sep_len_i};
  always_comb begin
    if (len_ext == 4'd0) begin
      eff_len = CW'(1);
    end else if (32'(len_ext) > MAX_SEP_LEN) begin
      eff_len = CW'(MAX_SEP_LEN);
    end else begin
      eff_len = CW'(len_ext);
    end
  end

  // Pending bytes with the new byte appended.
  assign wcnt = pcnt_i + 1'b1;
  always_comb begin
    for (int k = 0; k < MAX_SEP_LEN; k++) begin
      win[k] = (CW'(k) == pcnt_i) ? data_byte_i : pend_i[k];
    end
  end

  // ok[s]: after releasing s oldest bytes the rest is a separator prefix.
  always_comb begin
    for (int s = 0; s <= MAX_SEP_LEN; s++) begin
      ok[s] = (CW'(s) <= wcnt) && ((wcnt - CW'(s)) <= eff_len);
      for (int j = 0; j < MAX_SEP_LEN; j++) begin
        if (s + j < MAX_SEP_LEN) begin
          if ((CW'(j) < wcnt - CW'(s)) && (win[s+j] != sep_byte(sep_bytes_i, j))) begin
            ok[s] = 1'b0;
          end
        end
      end
    end
    sel = CW'(MAX_SEP_LEN);
    for (int s = MAX_SEP_LEN; s >= 0; s--) begin
      if (ok[s]) begin
        sel = CW'(s);
      end
    end
  end

  assign rem      = wcnt - sel;
  assign hit      = (rem == eff_len);
  assign skip_mid = (sel != '0) ? 1'b0 : skip_i;
  assign emit_eof = hit && !skip_mid;

  always_comb begin
    pend_o   = pend_i;
    pcnt_o   = pcnt_i;
    fields_o = fields_i;
    vhc_o    = vhc_i;
    skip_o   = skip_i;
    res_cnt_o = '0;
    for (int j = 0; j < MAX_SEP_LEN; j++) begin
      res_o[j] = '{kind: KIND_BYTE, data: 8'h00, done: 1'b0};
    end

    if (op_i == OP_BYTE) begin
      for (int j = 0; j < MAX_SEP_LEN; j++) begin
        if (CW'(j) < sel) begin
          res_o[j] = '{kind: KIND_BYTE, data: win[j], done: 1'b0};
        end else begin
          res_o[j] = '{kind: KIND_EOF, data: 8'h00, done: 1'b0};
        end
      end
      res_cnt_o = sel + CW'(emit_eof);
      vhc_o  = (sel != '0) ? 1'b1 : vhc_i;
      skip_o = skip_mid;
      if (hit) begin
        pcnt_o = '0;
        if (!skip_mid) begin
          fields_o = res_field_o;
          vhc_o    = 1'b0;
          skip_o   = collapse_i;
        end
      end else begin
        pcnt_o = rem;
        for (int k = 0; k < MAX_SEP_LEN; k++) begin
          for (int s = 0; s < MAX_SEP_LEN; s++) begin
            if ((sel == CW'(s)) && (k + s < MAX_SEP_LEN)) begin
              pend_o[k] = win[k+s];
            end
          end
        end
      end
    end else begin
      // End of line: flush pending bytes, then close the line.
      for (int j = 0; j < MAX_SEP_LEN; j++) begin
        if (CW'(j) < pcnt_i) begin
          res_o[j] = '{kind: KIND_BYTE, data: pend_i[j], done: 1'b0};
        end else if (collapse_i && !vhc_i && (pcnt_i == '0)) begin
          res_o[j] = '{kind: KIND_EOL_EMPTY, data: 8'h00, done: 1'b1};
        end else begin
          res_o[j] = '{kind: KIND_EOF, data: 8'h00, done: 1'b1};
        end
      end
      res_cnt_o = pcnt_i + 1'b1;
      pcnt_o    = '0;
      fields_o  = '0;
      vhc_o     = 1'b0;
      skip_o    = collapse_i;
    end
  end

endmodule

### rtl/pfs_res_buf.sv
`timescale 1ns / 1ps

module pfs_res_buf import pfs_pkg::*; #(
  parameter int MAX_SEP_LEN     = MAX_SEP_LEN_DEF,
  parameter int FIELD_NUM_WIDTH = FIELD_NUM_WIDTH_DEF,
  localparam int CW             = $clog2(MAX_SEP_LEN + 1),
  localparam int IW             = (MAX_SEP_LEN > 1) ? $clog2(MAX_SEP_LEN) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  res_t [MAX_SEP_LEN-1:0]     res_i,
  input  logic [CW-1:0]              res_cnt_i,
  input  logic [FIELD_NUM_WIDTH-1:0] res_field_i,
  output logic                       ready_o,
  pfs_out_if.source                  out_o
);

  res_t [MAX_SEP_LEN-1:0]     res_q;
  logic [FIELD_NUM_WIDTH-1:0] field_q;
  logic [CW-1:0]              cnt_q;
  logic [CW-1:0]              rd_q;
  logic [CW-1:0]              rd_inc;
  res_t                       head;

  assign rd_inc  = rd_q + 1'b1;
  assign ready_o = (rd_q == cnt_q) || ((rd_inc == cnt_q) && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= res_cnt_i;
      rd_q  <= '0;
    end else if (out_o.valid && out_o.ready) begin
      rd_q <= rd_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q   <= res_i;
      field_q <= res_field_i;
    end
  end

  assign head               = res_q[rd_q[IW-1:0]];
  assign out_o.valid        = (rd_q != cnt_q);
  assign out_o.kind         = head.kind;
  assign out_o.out_byte     = head.data;
  assign out_o.field_number = field_q;
  assign out_o.line_done    = head.done;

endmodule

### rtl/positional_field_splitter_top.sv
`timescale 1ns / 1ps
// The first result of a request is shown in the cycle after the request is taken.
// One request per cycle while each request yields at most one result and the output is ready;
// a request with more results holds the input until its last result leaves.
// Reset (rst_ni low, asynchronous): line state cleared, registers to their defaults,
// result buffer empty. The pending separator window is not reset.

module positional_field_splitter_top import pfs_pkg::*; #(
  parameter int MAX_SEP_LEN     = MAX_SEP_LEN_DEF,
  parameter int FIELD_NUM_WIDTH = FIELD_NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  pfs_in_if.sink               in_i,
  pfs_out_if.source            out_o
);

  localparam int CW = $clog2(MAX_SEP_LEN + 1);

  // Configuration registers.
  logic [31:0] sep_bytes_q;
  logic [2:0]  sep_len_q;
  logic        collapse_q;

  // Line state. The window holds the bytes that so far match a separator
  // prefix; it never holds a full separator, so MAX_SEP_LEN slots suffice.
  logic [7:0]                 pend_q [MAX_SEP_LEN];
  logic [7:0]                 pend_d [MAX_SEP_LEN];
  logic [CW-1:0]              pcnt_q, pcnt_d;
  logic [FIELD_NUM_WIDTH-1:0] fields_q, fields_d;
  logic                       vhc_q, vhc_d;
  logic                       skip_q, skip_d;

  // Results of the request at the input, computed in the same cycle.
  res_t [MAX_SEP_LEN-1:0]     res;
  logic [CW-1:0]              res_cnt;
  logic [FIELD_NUM_WIDTH-1:0] res_field;

  logic accept;

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_bytes_q <= SEP_BYTES_RST;
      sep_len_q   <= SEP_LEN_RST;
      collapse_q  <= COLLAPSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEP_BYTES: sep_bytes_q <= cfg_data_i;
        REG_SEP_LEN:   sep_len_q   <= cfg_data_i[2:0];
        REG_COLLAPSE:  collapse_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control part of the line state; skipping starts set since collapse resets to 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q   <= '0;
      fields_q <= '0;
      vhc_q    <= 1'b0;
      skip_q   <= COLLAPSE_RST;
    end else if (accept) begin
      pcnt_q   <= pcnt_d;
      fields_q <= fields_d;
      vhc_q    <= vhc_d;
      skip_q   <= skip_d;
    end
  end

  // Window bytes are only ever read below the pending count.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

  // The whole separator match for one byte is a parallel compare of every
  // possible release count against the separator, all of it combinational.
  pfs_step #(
    .MAX_SEP_LEN     (MAX_SEP_LEN),
    .FIELD_NUM_WIDTH (FIELD_NUM_WIDTH)
  ) u_step (
    .op_i        (in_i.op),
    .data_byte_i (in_i.data_byte),
    .sep_bytes_i (sep_bytes_q),
    .sep_len_i   (sep_len_q),
    .collapse_i  (collapse_q),
    .pend_i      (pend_q),
    .pcnt_i      (pcnt_q),
    .fields_i    (fields_q),
    .vhc_i       (vhc_q),
    .skip_i      (skip_q),
    .pend_o      (pend_d),
    .pcnt_o      (pcnt_d),
    .fields_o    (fields_d),
    .vhc_o       (vhc_d),
    .skip_o      (skip_d),
    .res_o       (res),
    .res_cnt_o   (res_cnt),
    .res_field_o (res_field)
  );

  // The buffer holds the results of one request and takes the next request
  // as soon as its last result leaves, in the same cycle.
  pfs_res_buf #(
    .MAX_SEP_LEN     (MAX_SEP_LEN),
    .FIELD_NUM_WIDTH (FIELD_NUM_WIDTH)
  ) u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .res_cnt_i   (res_cnt),
    .res_field_i (res_field),
    .ready_o     (in_i.ready),
    .out_o       (out_o)
  );

endmodule

### rtl/pfs_checker.sv
`timescale 1ns / 1ps

module pfs_checker import pfs_pkg::*; #(
  parameter int FIELD_NUM_WIDTH = FIELD_NUM_WIDTH_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [1:0]                 kind_i,
  input logic [7:0]                 out_byte_i,
  input logic [FIELD_NUM_WIDTH-1:0] field_number_i,
  input logic                       line_done_i
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(out_byte_i) && $stable(field_number_i) && $stable(line_done_i))
    else $error("stalled result changed");

  // A content byte never closes a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && line_done_i |-> kind_i != 2'(KIND_BYTE))
    else $error("line closed by a content byte");

  // An empty-line close only appears as the last result of a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == 2'(KIND_EOL_EMPTY)) |-> line_done_i)
    else $error("empty close without line done");

  // Markers carry a zero byte and known kinds only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != 2'(KIND_BYTE)) |->
    (out_byte_i == 8'h00) && ((kind_i == 2'(KIND_EOF)) || (kind_i == 2'(KIND_EOL_EMPTY))))
    else $error("bad marker result");

  // Field numbers start at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> field_number_i != '0)
    else $error("field number zero");

endmodule

bind positional_field_splitter_top pfs_checker #(
  .FIELD_NUM_WIDTH (FIELD_NUM_WIDTH)
) u_pfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .out_byte_i     (out_o.out_byte),
  .field_number_i (out_o.field_number),
  .line_done_i    (out_o.line_done)
);
